FILE: design/rdi_pkg.sv
// Shared package for the ray/disc intersection unit.
// Holds the register map, the disc configuration type and default constants.
// Used by every module in this folder but the port checker; depends on nothing.
`default_nettype none
package rdi_pkg;

   // default fraction bits of the Q format
   localparam int FRAC_BITS_DEF = 16;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X     = 4'd0,
      CSR_CENTER_Y     = 4'd1,
      CSR_CENTER_Z     = 4'd2,
      CSR_NORMAL_X     = 4'd3,
      CSR_NORMAL_Y     = 4'd4,
      CSR_NORMAL_Z     = 4'd5,
      CSR_RADIUS       = 4'd6,
      CSR_MIN_DISTANCE = 4'd7
   } csr_index_type;

   // reset values
   localparam logic [31:0] NORMAL_Y_RST     = 32'h0001_0000;
   localparam logic [30:0] RADIUS_RST       = 31'h0001_0000;
   localparam logic [30:0] MIN_DISTANCE_RST = 31'd7;

   // disc configuration as seen by front and back
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic [30:0]        radius;
      logic [30:0]        min_distance;
   } disc_cfg_type;

endpackage
`default_nettype wire

FILE: design/ray_disc_intersect_unit.sv
// Ray/disc intersection unit: one ray in, one hit/miss result out per item.
// The unit takes one ray every cycle while results are taken. An item passes
// 3 front stages, one queue slot and 37 back stages (setup, 31 division
// steps, t, product, offset, square, result); the one-bit-per-stage divider
// for t sets the depth. A four-entry queue between front and back lets rays
// be accepted while the result side stalls. Configuration is to be written
// through csr_* only while the unit is idle; the unit does not enforce this.
// csr_ready is always high and indexes above 7 are ignored.
// Depends on rdi_pkg, rdi_front, rdi_queue, rdi_back.
`default_nettype none
module ray_disc_intersect_unit #(
   parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rdi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rdi_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [31:0]                req_origin_x,
   input  wire logic signed [31:0]                req_origin_y,
   input  wire logic signed [31:0]                req_origin_z,
   input  wire logic signed [31:0]                req_direction_x,
   input  wire logic signed [31:0]                req_direction_y,
   input  wire logic signed [31:0]                req_direction_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_is_hit,
   output logic signed [31:0]                     rsp_distance,
   output logic signed [31:0]                     rsp_hit_normal_x,
   output logic signed [31:0]                     rsp_hit_normal_y,
   output logic signed [31:0]                     rsp_hit_normal_z
);

   localparam int SUM_W = 67 - FRAC_BITS;
   localparam int Q_W   = 2 * SUM_W + 6 * 32;

   rdi_pkg::disc_cfg_type cfg_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{center_x: '0, center_y: '0, center_z: '0, normal_x: '0,
                     normal_y: rdi_pkg::NORMAL_Y_RST, normal_z: '0,
                     radius: rdi_pkg::RADIUS_RST,
                     min_distance: rdi_pkg::MIN_DISTANCE_RST};
      end else if (csr_valid) begin
         case (rdi_pkg::csr_index_type'(csr_index))
            rdi_pkg::CSR_CENTER_X:     cfg_ff.center_x     <= csr_data;
            rdi_pkg::CSR_CENTER_Y:     cfg_ff.center_y     <= csr_data;
            rdi_pkg::CSR_CENTER_Z:     cfg_ff.center_z     <= csr_data;
            rdi_pkg::CSR_NORMAL_X:     cfg_ff.normal_x     <= csr_data;
            rdi_pkg::CSR_NORMAL_Y:     cfg_ff.normal_y     <= csr_data;
            rdi_pkg::CSR_NORMAL_Z:     cfg_ff.normal_z     <= csr_data;
            rdi_pkg::CSR_RADIUS:       cfg_ff.radius       <= csr_data[30:0];
            rdi_pkg::CSR_MIN_DISTANCE: cfg_ff.min_distance <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // front
   logic                    f_valid, q_full;
   logic signed [SUM_W-1:0] f_num, f_den;
   logic signed [31:0]      f_o [3];
   logic signed [31:0]      f_d [3];

   rdi_front #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .origin_x    (req_origin_x),
      .origin_y    (req_origin_y),
      .origin_z    (req_origin_z),
      .direction_x (req_direction_x),
      .direction_y (req_direction_y),
      .direction_z (req_direction_z),
      .out_valid   (f_valid),
      .out_full    (q_full),
      .out_num     (f_num),
      .out_den     (f_den),
      .out_o       (f_o),
      .out_d       (f_d)
   );

   // queue
   logic [Q_W-1:0]          q_wdata, q_rdata;
   logic                    q_pop, q_ne;
   logic signed [SUM_W-1:0] b_num, b_den;
   logic signed [31:0]      b_o [3];
   logic signed [31:0]      b_d [3];

   assign q_wdata = {f_num, f_den, f_o[0], f_o[1], f_o[2], f_d[0], f_d[1], f_d[2]};
   assign {b_num, b_den, b_o[0], b_o[1], b_o[2], b_d[0], b_d[1], b_d[2]} = q_rdata;

   rdi_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_ne),
      .pop_data  (q_rdata)
   );

   // back
   rdi_back #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (q_ne),
      .in_pop       (q_pop),
      .in_num       (b_num),
      .in_den       (b_den),
      .in_o         (b_o),
      .in_d         (b_d),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_is_hit   (rsp_is_hit),
      .out_distance (rsp_distance),
      .out_normal_x (rsp_hit_normal_x),
      .out_normal_y (rsp_hit_normal_y),
      .out_normal_z (rsp_hit_normal_z)
   );

endmodule
`default_nettype wire

FILE: design/rdi_front.sv
// Front part: accepts rays and forms the plane numerator and denominator.
// Three register stages; stalls only when the queue behind it is full.
// Depends on rdi_pkg.
`default_nettype none
module rdi_front #(
   parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF,
   parameter int SUM_W     = 67 - FRAC_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rdi_pkg::disc_cfg_type cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic signed [31:0]   origin_x,
   input  wire logic signed [31:0]   origin_y,
   input  wire logic signed [31:0]   origin_z,
   input  wire logic signed [31:0]   direction_x,
   input  wire logic signed [31:0]   direction_y,
   input  wire logic signed [31:0]   direction_z,
   output logic                      out_valid,
   input  wire logic                 out_full,
   output logic signed [SUM_W-1:0]   out_num,
   output logic signed [SUM_W-1:0]   out_den,
   output logic signed [31:0]        out_o [3],
   output logic signed [31:0]        out_d [3]
);

   logic [2:0]         v_ff, v_in;
   logic               en;
   logic signed [31:0] o1_ff [3];
   logic signed [31:0] d1_ff [3];
   logic signed [32:0] diff_ff [3];
   logic signed [31:0] o2_ff [3];
   logic signed [31:0] d2_ff [3];
   logic signed [64:0] pn_ff [3];
   logic signed [63:0] pd_ff [3];
   logic signed [31:0] o3_ff [3];
   logic signed [31:0] d3_ff [3];
   logic signed [SUM_W-1:0] num_ff, den_ff, num_in, den_in;
   logic signed [31:0] cen [3];
   logic signed [31:0] nrm [3];

   assign cen[0] = cfg.center_x;
   assign cen[1] = cfg.center_y;
   assign cen[2] = cfg.center_z;
   assign nrm[0] = cfg.normal_x;
   assign nrm[1] = cfg.normal_y;
   assign nrm[2] = cfg.normal_z;

   // whole front advances unless last stage is blocked
   assign en       = !v_ff[2] || !out_full;
   assign in_ready = en;
   assign v_in     = {v_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // floored products summed
   always_comb begin
      num_in = SUM_W'(pn_ff[0] >>> FRAC_BITS) + SUM_W'(pn_ff[1] >>> FRAC_BITS)
             + SUM_W'(pn_ff[2] >>> FRAC_BITS);
      den_in = SUM_W'(pd_ff[0] >>> FRAC_BITS) + SUM_W'(pd_ff[1] >>> FRAC_BITS)
             + SUM_W'(pd_ff[2] >>> FRAC_BITS);
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         o1_ff[0] <= origin_x;
         o1_ff[1] <= origin_y;
         o1_ff[2] <= origin_z;
         d1_ff[0] <= direction_x;
         d1_ff[1] <= direction_y;
         d1_ff[2] <= direction_z;
         diff_ff[0] <= 33'(cen[0]) - 33'(origin_x);
         diff_ff[1] <= 33'(cen[1]) - 33'(origin_y);
         diff_ff[2] <= 33'(cen[2]) - 33'(origin_z);
         for (int i = 0; i < 3; i++) begin
            o2_ff[i] <= o1_ff[i];
            d2_ff[i] <= d1_ff[i];
            pn_ff[i] <= diff_ff[i] * 65'(nrm[i]);
            pd_ff[i] <= 64'(d1_ff[i]) * 64'(nrm[i]);
            o3_ff[i] <= o2_ff[i];
            d3_ff[i] <= d2_ff[i];
         end
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_o     = o3_ff;
   assign out_d     = d3_ff;

endmodule
`default_nettype wire

FILE: design/rdi_queue.sv
// Short queue between front and back so each can stall on its own.
// Register array with read and write pointers and a fill count.
// Depends on rdi_pkg.
`default_nettype none
module rdi_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int DEPTH = rdi_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full      = cnt_ff == CNT_W'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem[rd_ff];

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

FILE: design/rdi_back.sv
// Back part: divides for t one quotient bit per stage, forms the hit point
// and runs the min distance and radius tests, ending in the result register.
// Depends on rdi_pkg.
`default_nettype none
module rdi_back #(
   parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF,
   parameter int SUM_W     = 67 - FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rdi_pkg::disc_cfg_type cfg,
   input  wire logic                  in_valid,
   output logic                       in_pop,
   input  wire logic signed [SUM_W-1:0] in_num,
   input  wire logic signed [SUM_W-1:0] in_den,
   input  wire logic signed [31:0]    in_o [3],
   input  wire logic signed [31:0]    in_d [3],
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic                       out_is_hit,
   output logic signed [31:0]         out_distance,
   output logic signed [31:0]         out_normal_x,
   output logic signed [31:0]         out_normal_y,
   output logic signed [31:0]         out_normal_z
);

   localparam int QB  = 31;                // quotient bits
   localparam int R_W = SUM_W + 1;
   localparam int X_W = SUM_W + FRAC_BITS;
   localparam int C_W = SUM_W + 32;
   localparam int E_W = 66 - FRAC_BITS;

   logic en;

   // divider pipeline, index 0 is the setup stage
   logic              dv_v   [QB+1];
   logic [R_W-1:0]    dv_r   [QB+1];
   logic [30:0]       dv_low [QB+1];
   logic [QB-1:0]     dv_q   [QB+1];
   logic [SUM_W-1:0]  dv_b   [QB+1];
   logic              dv_neg [QB+1];
   logic              dv_sat [QB+1];
   logic              dv_miss[QB+1];
   logic signed [31:0] dv_o  [QB+1][3];
   logic signed [31:0] dv_d  [QB+1][3];

   logic [SUM_W-1:0]  a_abs, b_abs;
   logic [X_W-1:0]    x_in;

   assign en     = !out_valid || out_ready;
   assign in_pop = en && in_valid;

   // setup: magnitudes, sign, overflow check
   always_comb begin
      a_abs = in_num[SUM_W-1] ? SUM_W'(-in_num) : SUM_W'(in_num);
      b_abs = in_den[SUM_W-1] ? SUM_W'(-in_den) : SUM_W'(in_den);
      x_in  = {a_abs, {FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v[0] <= 1'b0;
      end else if (en) begin
         dv_v[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_r[0]    <= R_W'(x_in >> QB);
         dv_low[0]  <= x_in[30:0];
         dv_q[0]    <= '0;
         dv_b[0]    <= b_abs;
         dv_neg[0]  <= in_num[SUM_W-1] != in_den[SUM_W-1];
         dv_sat[0]  <= C_W'(a_abs) >= (C_W'(b_abs) << (QB - FRAC_BITS));
         dv_miss[0] <= in_den == '0;
         dv_o[0]    <= in_o;
         dv_d[0]    <= in_d;
      end
   end

   // one restoring division step per stage
   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [R_W-1:0] r2;
      logic           ge;
      assign r2 = {dv_r[k][R_W-2:0], dv_low[k][30]};
      assign ge = r2 >= {1'b0, dv_b[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v[k+1] <= 1'b0;
         end else if (en) begin
            dv_v[k+1] <= dv_v[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_r[k+1]    <= ge ? r2 - {1'b0, dv_b[k]} : r2;
            dv_low[k+1]  <= {dv_low[k][29:0], 1'b0};
            dv_q[k+1]    <= {dv_q[k][QB-2:0], ge};
            dv_b[k+1]    <= dv_b[k];
            dv_neg[k+1]  <= dv_neg[k];
            dv_sat[k+1]  <= dv_sat[k];
            dv_miss[k+1] <= dv_miss[k];
            dv_o[k+1]    <= dv_o[k];
            dv_d[k+1]    <= dv_d[k];
         end
      end
   end

   // t with saturation, min distance test
   logic               t_v_ff, t_miss_ff, t_miss_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] t_o_ff [3];
   logic signed [31:0] t_d_ff [3];

   always_comb begin
      if (dv_sat[QB]) begin
         t_in = dv_neg[QB] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         t_in = dv_neg[QB] ? -$signed({1'b0, dv_q[QB]}) : $signed({1'b0, dv_q[QB]});
      end
      t_miss_in = dv_miss[QB] || (33'(t_in) <= $signed({2'b00, cfg.min_distance}));
   end

   // hit point products
   logic               m_v_ff, m_miss_ff;
   logic signed [31:0] m_t_ff;
   logic signed [63:0] m_p_ff [3];
   logic signed [31:0] m_o_ff [3];

   // offset from center, range check
   logic               e_v_ff, e_miss_ff;
   logic signed [31:0] e_t_ff;
   logic [30:0]        e_mag_ff [3];
   logic signed [E_W-1:0] e_val [3];
   logic [2:0]         e_far;
   logic signed [E_W-1:0] rad_e;

   assign rad_e = E_W'($signed({1'b0, cfg.radius}));

   function automatic logic signed [31:0] dv_center(input int idx);
      logic signed [31:0] c;
      case (idx)
         0:       c = cfg.center_x;
         1:       c = cfg.center_y;
         default: c = cfg.center_z;
      endcase
      return c;
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_val[i] = E_W'(m_o_ff[i]) + E_W'(m_p_ff[i] >>> FRAC_BITS) - E_W'(dv_center(i));
         e_far[i] = (e_val[i] > rad_e) || (e_val[i] < -rad_e);
      end
   end

   // squares
   logic               s_v_ff, s_miss_ff;
   logic signed [31:0] s_t_ff;
   logic [61:0]        s_sq_ff [3];
   logic [61:0]        s_rr_ff;
   logic [63:0]        sum;

   assign sum = 64'(s_sq_ff[0]) + 64'(s_sq_ff[1]) + 64'(s_sq_ff[2]);

   // result register
   logic               o_v_ff, o_hit_ff, o_hit_in;
   logic signed [31:0] o_dist_ff, o_nx_ff, o_ny_ff, o_nz_ff;

   assign o_hit_in = !s_miss_ff && (sum <= 64'(s_rr_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         t_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         s_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         t_v_ff <= dv_v[QB];
         m_v_ff <= t_v_ff;
         e_v_ff <= m_v_ff;
         s_v_ff <= e_v_ff;
         o_v_ff <= s_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff      <= t_in;
         t_miss_ff <= t_miss_in;
         t_o_ff    <= dv_o[QB];
         t_d_ff    <= dv_d[QB];

         m_t_ff    <= t_ff;
         m_miss_ff <= t_miss_ff;
         m_o_ff    <= t_o_ff;
         for (int i = 0; i < 3; i++) begin
            m_p_ff[i] <= 64'(t_d_ff[i]) * 64'(t_ff);
         end

         e_t_ff    <= m_t_ff;
         e_miss_ff <= m_miss_ff || (e_far != '0);
         for (int i = 0; i < 3; i++) begin
            e_mag_ff[i] <= e_val[i][E_W-1] ? 31'(-e_val[i]) : 31'(e_val[i]);
         end

         s_t_ff    <= e_t_ff;
         s_miss_ff <= e_miss_ff;
         for (int i = 0; i < 3; i++) begin
            s_sq_ff[i] <= 62'(e_mag_ff[i]) * 62'(e_mag_ff[i]);
         end
         s_rr_ff   <= 62'(cfg.radius) * 62'(cfg.radius);

         o_hit_ff  <= o_hit_in;
         o_dist_ff <= o_hit_in ? s_t_ff : '0;
         o_nx_ff   <= o_hit_in ? cfg.normal_x : '0;
         o_ny_ff   <= o_hit_in ? cfg.normal_y : '0;
         o_nz_ff   <= o_hit_in ? cfg.normal_z : '0;
      end
   end

   assign out_valid    = o_v_ff;
   assign out_is_hit   = o_hit_ff;
   assign out_distance = o_dist_ff;
   assign out_normal_x = o_nx_ff;
   assign out_normal_y = o_ny_ff;
   assign out_normal_z = o_nz_ff;

endmodule
`default_nettype wire

FILE: design/rdi_checker.sv
// Port-level checker for the ray/disc intersection unit, with its bind.
// Sees only the top-level ports and uses nothing from rdi_pkg.
`default_nettype none
module rdi_port_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_is_hit,
   input wire logic signed [31:0] rsp_distance,
   input wire logic signed [31:0] rsp_hit_normal_x,
   input wire logic signed [31:0] rsp_hit_normal_y,
   input wire logic signed [31:0] rsp_hit_normal_z
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
         && $stable(rsp_is_hit))
      else $error("result changed while stalled");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_hit |-> rsp_distance == 0 && rsp_hit_normal_x == 0
         && rsp_hit_normal_y == 0 && rsp_hit_normal_z == 0)
      else $error("miss with nonzero fields");

   // a hit lies beyond the non-negative minimum distance
   a_hit_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_hit |-> rsp_distance > 0)
      else $error("hit with non-positive distance");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ray_disc_intersect_unit rdi_port_checker u_rdi_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_is_hit       (rsp_is_hit),
   .rsp_distance     (rsp_distance),
   .rsp_hit_normal_x (rsp_hit_normal_x),
   .rsp_hit_normal_y (rsp_hit_normal_y),
   .rsp_hit_normal_z (rsp_hit_normal_z)
);
`default_nettype wire
